[hw/rtl/vrp_pkg.sv]
package vrp_pkg;

	localparam int COORD_W = 24;
	localparam int ANG_W = 16;
	localparam int STAGES = 16;
	localparam int GUARD = 4;
	localparam logic [31:0] GAIN_Q31 = 32'd1304065748;

	typedef enum logic [2:0] {
		CMD_RECT  = 3'd0,
		CMD_POLAR = 3'd1,
		CMD_ADD   = 3'd2,
		CMD_SUB   = 3'd3,
		CMD_NEG   = 3'd4,
		CMD_SCALE = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic [COORD_W-2:0] a_mag;
		logic signed [ANG_W-1:0] a_ang;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [15:0] factor;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] res_x;
		logic signed [COORD_W-1:0] res_y;
		logic [COORD_W-1:0] res_mag;
		logic signed [ANG_W-1:0] res_ang;
		logic overflow;
		logic invalid;
	} out_word_t;

	// atan(2^-i), 2^31 = pi
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
			5'd20: r = 32'd652;       5'd21: r = 32'd326;
			5'd22: r = 32'd163;       5'd23: r = 32'd81;
			5'd24: r = 32'd41;        5'd25: r = 32'd20;
			5'd26: r = 32'd10;        5'd27: r = 32'd5;
			5'd28: r = 32'd3;         5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/vrp_cordic.sv]
// Unrolled CORDIC, one register stage per iteration.
// mode 0 vectoring (drive y to zero), 1 rotation (drive z to zero).
module vrp_cordic #(
	parameter int W = 32,
	parameter int N = 16,
	parameter int TW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  logic mode,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic [31:0] z_in,
	input  logic [TW-1:0] tag_in,
	output logic out_vld,
	output logic signed [W-1:0] x_out,
	output logic signed [W-1:0] y_out,
	output logic [31:0] z_out,
	output logic [TW-1:0] tag_out
);
	import vrp_pkg::*;

	logic                 vld_s [N+1];
	logic                 mode_s [N+1];
	logic signed [W-1:0]  x_s [N+1];
	logic signed [W-1:0]  y_s [N+1];
	logic [31:0]          z_s [N+1];
	logic [TW-1:0]        tag_s [N+1];

	assign vld_s[0] = in_vld;
	assign mode_s[0] = mode;
	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = z_in;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < N; i++) begin : g_it
		logic cw;
		logic signed [W-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		// cw: x += y>>i, y -= x>>i, z += atan
		assign cw = mode_s[i] ? z_s[i][31] : !y_s[i][W-1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk) begin
			mode_s[i+1] <= mode_s[i];
			tag_s[i+1] <= tag_s[i];
			if (cw) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + atan_lut(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - atan_lut(5'(i));
			end
		end
	end

	assign out_vld = vld_s[N];
	assign x_out = x_s[N];
	assign y_out = y_s[N];
	assign z_out = z_s[N];
	assign tag_out = tag_s[N];
endmodule

[hw/rtl/vector_rect_polar_unit.sv]
// channel  | ports                 | handshake
// input    | start, busy, in_word  | taken when start && !busy
// result   | done, out_word        | one cycle pulse on done
// done rises once the word has passed the pipeline, one word per cycle;
// busy is always low. The delay is set by the unrolled CORDIC chain plus the
// front end, setup, gain multiply and output stages.
// Reset clears valid bits only; payload is not reset.
// Results cannot be stalled: done pulses exactly once per accepted word.
module vector_rect_polar_unit #(
	parameter int CORDIC_STAGES = vrp_pkg::STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  vrp_pkg::in_word_t in_word,
	output logic done,
	output vrp_pkg::out_word_t out_word
);
	import vrp_pkg::*;

	localparam int CW = COORD_W + GUARD + 4;
	localparam int TW = 3 + 2*COORD_W + 1 + COORD_W - 1 + ANG_W;
	// tag codes beside the cmd values
	localparam logic [2:0] TAG_ZERO = 3'd6;
	localparam logic [2:0] TAG_INV = 3'd7;

	assign busy = 1'b0;
	logic acc;
	assign acc = start && !busy;

	// s1: arithmetic, product with rounding
	logic v_s1;
	in_word_t w_s1;
	logic signed [COORD_W+16:0] px_s1, py_s1;
	logic [COORD_W+GUARD+31:0] gm_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		w_s1 <= in_word;
		px_s1 <= (COORD_W+17)'(in_word.a_x) * (COORD_W+17)'(in_word.factor) +
			(COORD_W+17)'(128);
		py_s1 <= (COORD_W+17)'(in_word.a_y) * (COORD_W+17)'(in_word.factor) +
			(COORD_W+17)'(128);
		gm_s1 <= {in_word.a_mag, {GUARD{1'b0}}} * GAIN_Q31 + (1 << 30);
	end

	// s2: select and saturate, CORDIC setup
	logic signed [COORD_W+17:0] rx, ry;
	logic signed [COORD_W-1:0] sx, sy;
	logic ovf, inv, zero;
	logic signed [CW-1:0] cx, cy, gx;
	logic [31:0] cz;
	logic cmode;
	localparam logic signed [COORD_W+17:0] HI = (COORD_W+18)'((1 << (COORD_W-1)) - 1);
	localparam logic signed [COORD_W+17:0] LO = -HI - 1;
	always_comb begin
		rx = '0; ry = '0;
		case (w_s1.cmd)
			CMD_RECT: begin
				rx = (COORD_W+18)'(w_s1.a_x); ry = (COORD_W+18)'(w_s1.a_y);
			end
			CMD_ADD: begin
				rx = (COORD_W+18)'(w_s1.a_x) + (COORD_W+18)'(w_s1.b_x);
				ry = (COORD_W+18)'(w_s1.a_y) + (COORD_W+18)'(w_s1.b_y);
			end
			CMD_SUB: begin
				rx = (COORD_W+18)'(w_s1.a_x) - (COORD_W+18)'(w_s1.b_x);
				ry = (COORD_W+18)'(w_s1.a_y) - (COORD_W+18)'(w_s1.b_y);
			end
			CMD_NEG: begin
				rx = -(COORD_W+18)'(w_s1.a_x); ry = -(COORD_W+18)'(w_s1.a_y);
			end
			CMD_SCALE: begin
				rx = (COORD_W+18)'(px_s1 >>> 8); ry = (COORD_W+18)'(py_s1 >>> 8);
			end
			default: ;
		endcase
		ovf = 1'b0;
		if (rx > HI) begin sx = HI[COORD_W-1:0]; ovf = 1'b1; end
		else if (rx < LO) begin sx = LO[COORD_W-1:0]; ovf = 1'b1; end
		else sx = rx[COORD_W-1:0];
		if (ry > HI) begin sy = HI[COORD_W-1:0]; ovf = 1'b1; end
		else if (ry < LO) begin sy = LO[COORD_W-1:0]; ovf = 1'b1; end
		else sy = ry[COORD_W-1:0];
		inv = w_s1.cmd > CMD_SCALE;
		if (w_s1.cmd == CMD_POLAR || inv) ovf = 1'b0;
		zero = sx == '0 && sy == '0;
		cmode = w_s1.cmd == CMD_POLAR;
		gx = CW'(gm_s1 >> 31);
		if (cmode) begin
			cz = {w_s1.a_ang, {(32-ANG_W){1'b0}}};
			cy = '0;
			if (cz[31] != cz[30]) begin cx = -gx; cz = cz - 32'h8000_0000; end
			else cx = gx;
		end else begin
			cx = CW'(sx) <<< GUARD;
			cy = CW'(sy) <<< GUARD;
			cz = '0;
			if (sx < 0) begin cx = -cx; cy = -cy; cz = 32'h8000_0000; end
		end
	end

	logic v_s2, m_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic [31:0] z_s2;
	logic [TW-1:0] t_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		m_s2 <= cmode;
		x_s2 <= cx; y_s2 <= cy; z_s2 <= cz;
		t_s2 <= {inv ? TAG_INV : ((zero && !cmode) ? TAG_ZERO : w_s1.cmd),
			sx, sy, ovf, w_s1.a_mag, w_s1.a_ang};
	end

	logic v_c;
	logic signed [CW-1:0] x_c, y_c;
	logic [31:0] z_c;
	logic [TW-1:0] t_c;
	vrp_cordic #(.W(CW), .N(CORDIC_STAGES), .TW(TW)) u_cordic (
		.clk(clk), .arst_n(arst_n), .in_vld(v_s2), .mode(m_s2),
		.x_in(x_s2), .y_in(y_s2), .z_in(z_s2), .tag_in(t_s2),
		.out_vld(v_c), .x_out(x_c), .y_out(y_c), .z_out(z_c), .tag_out(t_c));

	// s3: gain multiply (vectoring), rounding
	logic [2:0] tc;
	logic signed [COORD_W-1:0] tsx, tsy;
	logic tov;
	logic [COORD_W-2:0] tmag;
	logic signed [ANG_W-1:0] tang;
	assign {tc, tsx, tsy, tov, tmag, tang} = t_c;

	logic v_s3;
	logic [2:0] c_s3;
	logic signed [COORD_W-1:0] sx_s3, sy_s3;
	logic ov_s3;
	logic [COORD_W-2:0] am_s3;
	logic signed [ANG_W-1:0] aa_s3, za_s3;
	logic [CW+31:0] mg_s3;
	logic signed [CW-1:0] rx_s3, ry_s3;
	logic [31:0] zr;
	assign zr = z_c + 32'(1 << (31 - ANG_W));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_c;
	end
	always_ff @(posedge clk) begin
		c_s3 <= tc; sx_s3 <= tsx; sy_s3 <= tsy; ov_s3 <= tov;
		am_s3 <= tmag; aa_s3 <= tang;
		mg_s3 <= (x_c < 0 ? '0 : (CW+32)'(x_c)) * GAIN_Q31 +
			(CW+32)'(64'd1 << (30 + GUARD));
		za_s3 <= zr[31 -: ANG_W];
		rx_s3 <= (x_c + CW'(1 << (GUARD-1))) >>> GUARD;
		ry_s3 <= (y_c + CW'(1 << (GUARD-1))) >>> GUARD;
	end

	logic signed [CW-1:0] hr, lr;
	logic [CW+31:0] mv;
	logic ovp;
	out_word_t ow;
	assign hr = CW'((1 << (COORD_W-1)) - 1);
	assign lr = -hr - 1;
	always_comb begin
		ow = '0;
		ovp = 1'b0;
		mv = mg_s3 >> (31 + GUARD);
		case (c_s3)
			TAG_INV: ow.invalid = 1'b1;
			TAG_ZERO: begin ow.res_x = sx_s3; ow.res_y = sy_s3; ow.overflow = ov_s3; end
			CMD_POLAR: begin
				if (rx_s3 > hr) begin ow.res_x = hr[COORD_W-1:0]; ovp = 1'b1; end
				else if (rx_s3 < lr) begin ow.res_x = lr[COORD_W-1:0]; ovp = 1'b1; end
				else ow.res_x = rx_s3[COORD_W-1:0];
				if (ry_s3 > hr) begin ow.res_y = hr[COORD_W-1:0]; ovp = 1'b1; end
				else if (ry_s3 < lr) begin ow.res_y = lr[COORD_W-1:0]; ovp = 1'b1; end
				else ow.res_y = ry_s3[COORD_W-1:0];
				ow.overflow = ovp;
				ow.res_mag = COORD_W'(am_s3);
				ow.res_ang = aa_s3;
			end
			default: begin
				ow.res_x = sx_s3; ow.res_y = sy_s3; ow.overflow = ov_s3;
				ow.res_mag = (mv > (CW+32)'({COORD_W{1'b1}})) ? {COORD_W{1'b1}}
					: mv[COORD_W-1:0];
				ow.res_ang = za_s3;
			end
		endcase
	end

	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) out_word <= ow;
	assign done = v_s4;

	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_word.invalid |-> out_word.res_mag == '0 && !out_word.overflow)
		else $error("invalid word not cleared");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ##(CORDIC_STAGES+2) done)
		else $error("word lost in pipeline");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import vrp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = STAGES + 16;
	localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
	localparam longint COORD_LO = -(64'sd1 <<< (COORD_W - 1));

	class vec_scoreboard;
		out_word_t pending[$];
		int errors = 0;

		function automatic void polar_of(input longint x, input longint y,
				output logic [COORD_W-1:0] mag, output logic [ANG_W-1:0] ang);
			longint px, py, dx, dy;
			logic [31:0] z;
			logic [31:0] zr;
			longint unsigned m;
			z = 32'd0;
			if (x == 0 && y == 0) begin
				mag = '0;
				ang = '0;
				return;
			end
			px = x * 16;
			py = y * 16;
			if (px < 0) begin
				px = -px;
				py = -py;
				z = 32'h8000_0000;
			end
			for (int i = 0; i < STAGES; i++) begin
				dx = py >>> i;
				dy = px >>> i;
				if (py >= 0) begin
					px += dx; py -= dy; z += atan_tab(i);
				end else begin
					px -= dx; py += dy; z -= atan_tab(i);
				end
			end
			if (px < 0)
				px = 0;
			m = (longint'(unsigned'(px)) * 64'd1304065748 + (64'd1 << (30 + GUARD)))
				>> (31 + GUARD);
			if (m > (64'd1 << COORD_W) - 1)
				m = (64'd1 << COORD_W) - 1;
			mag = m[COORD_W-1:0];
			zr = z + (32'd1 << (31 - ANG_W));
			ang = zr[31 -: ANG_W];
		endfunction

		function automatic logic [31:0] atan_tab(input int i);
			logic [31:0] t [0:15];
			t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
				32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
				32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
				32'd166886, 32'd83443, 32'd41722, 32'd20861};
			return t[i];
		endfunction

		function automatic void rect_of(input logic [COORD_W-2:0] mag,
				input logic [ANG_W-1:0] angb, output longint x, output longint y);
			logic [31:0] z;
			longint px, py, dx, dy;
			longint unsigned p;
			z = {angb, {(32 - ANG_W){1'b0}}};
			py = 0;
			p = ((longint'(mag) << GUARD) * 64'd1304065748 + (64'd1 << 30)) >> 31;
			px = longint'(p);
			if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
				px = -px;
				z -= 32'h8000_0000;
			end
			for (int i = 0; i < STAGES; i++) begin
				dx = py >>> i;
				dy = px >>> i;
				if (!z[31]) begin
					px -= dx; py += dy; z -= atan_tab(i);
				end else begin
					px += dx; py -= dy; z += atan_tab(i);
				end
			end
			x = (px + 8) >>> GUARD;
			y = (py + 8) >>> GUARD;
		endfunction

		function automatic longint clamp(input longint v, inout bit ov);
			if (v > COORD_HI) begin ov = 1; return COORD_HI; end
			if (v < COORD_LO) begin ov = 1; return COORD_LO; end
			return v;
		endfunction

		function automatic out_word_t predict(input in_word_t w);
			out_word_t r;
			longint ax, ay, bx, by, f, rx, ry;
			bit ov;
			r = '0;
			ov = 0;
			if (w.cmd > CMD_SCALE) begin
				r.invalid = 1'b1;
				return r;
			end
			ax = $signed(w.a_x); ay = $signed(w.a_y);
			bx = $signed(w.b_x); by = $signed(w.b_y);
			f = $signed(w.factor);
			case (cmd_t'(w.cmd))
				CMD_RECT: begin rx = ax; ry = ay; end
				CMD_POLAR: rect_of(w.a_mag, w.a_ang, rx, ry);
				CMD_ADD: begin rx = ax + bx; ry = ay + by; end
				CMD_SUB: begin rx = ax - bx; ry = ay - by; end
				CMD_NEG: begin rx = -ax; ry = -ay; end
				default: begin
					rx = (ax * f + 128) >>> 8;
					ry = (ay * f + 128) >>> 8;
				end
			endcase
			rx = clamp(rx, ov);
			ry = clamp(ry, ov);
			r.res_x = rx[COORD_W-1:0];
			r.res_y = ry[COORD_W-1:0];
			if (w.cmd == CMD_POLAR) begin
				r.res_mag = {1'b0, w.a_mag};
				r.res_ang = w.a_ang;
			end else
				polar_of(rx, ry, r.res_mag, r.res_ang);
			r.overflow = ov;
			return r;
		endfunction

		function void note(input in_word_t w);
			pending.push_back(predict(w));
		endfunction

		function void field(input string n, input longint e, input longint g);
			if (e != g) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, n, e, g);
			end
		endfunction

		function void check(input out_word_t g);
			out_word_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h", $time, g);
				return;
			end
			e = pending.pop_front();
			field("res_x", e.res_x, g.res_x);
			field("res_y", e.res_y, g.res_y);
			field("res_mag", e.res_mag, g.res_mag);
			field("res_ang", e.res_ang, g.res_ang);
			field("overflow", e.overflow, g.overflow);
			field("invalid", e.invalid, g.invalid);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	in_word_t in_word = '0;
	logic done;
	out_word_t out_word;

	vec_scoreboard sb = new();
	int quiet_cycles = 0;
	bit calm = 0;

	vector_rect_polar_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_word(in_word), .done(done), .out_word(out_word)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note(in_word);
			if (done)
				sb.check(out_word);
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send(input in_word_t w);
		if (!calm && $urandom_range(99) < 3) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return COORD_W'($urandom);
			1: return COORD_W'($signed($urandom_range(8191)) - 4096);
			2: return $urandom_range(1) ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}};
			default: return {{12{$urandom_range(1) ? 1'b1 : 1'b0}}, 12'(unsigned'($urandom))};
		endcase
	endfunction

	function automatic in_word_t mk(input logic [2:0] c, input longint ax, input longint ay,
			input longint mg, input longint an, input longint bx, input longint by,
			input longint f);
		in_word_t w;
		w.cmd = c; w.a_x = COORD_W'(ax); w.a_y = COORD_W'(ay);
		w.a_mag = (COORD_W-1)'(mg); w.a_ang = ANG_W'(an);
		w.b_x = COORD_W'(bx); w.b_y = COORD_W'(by); w.factor = 16'(f);
		return w;
	endfunction

	initial begin
		in_word_t w;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed words
		send(mk(CMD_RECT, 0, 0, 0, 0, 0, 0, 0));
		send(mk(CMD_RECT, COORD_HI, COORD_HI, 0, 0, 0, 0, 0));
		send(mk(CMD_RECT, COORD_LO, COORD_LO, 0, 0, 0, 0, 0));
		send(mk(CMD_RECT, COORD_LO, 0, 0, 0, 0, 0, 0));
		send(mk(CMD_RECT, -4096, 0, 0, 0, 0, 0, 0));
		send(mk(CMD_RECT, 0, -4096, 0, 0, 0, 0, 0));
		send(mk(CMD_POLAR, 0, 0, 0, 12345, 0, 0, 0));
		send(mk(CMD_POLAR, 0, 0, (1 << 23) - 1, 0, 0, 0, 0));
		send(mk(CMD_POLAR, 0, 0, (1 << 23) - 1, -32768, 0, 0, 0));
		send(mk(CMD_POLAR, 0, 0, 4096, 16384, 0, 0, 0));
		send(mk(CMD_POLAR, 0, 0, 4096, -16384, 0, 0, 0));
		send(mk(CMD_POLAR, 0, 0, (1 << 23) - 1, 8192, 0, 0, 0));
		send(mk(CMD_ADD, COORD_HI, COORD_LO, 0, 0, COORD_HI, COORD_LO, 0));
		send(mk(CMD_ADD, 4096, -4096, 0, 0, -4096, 4096, 0));
		send(mk(CMD_SUB, COORD_LO, COORD_HI, 0, 0, COORD_HI, COORD_LO, 0));
		send(mk(CMD_SUB, 100, 200, 0, 0, 100, 200, 0));
		send(mk(CMD_NEG, COORD_LO, COORD_HI, 0, 0, 0, 0, 0));
		send(mk(CMD_SCALE, COORD_HI, COORD_LO, 0, 0, 0, 0, -32768));
		send(mk(CMD_SCALE, COORD_HI, COORD_LO, 0, 0, 0, 0, 32767));
		send(mk(CMD_SCALE, -5, 3, 0, 0, 0, 0, 128));
		send(mk(CMD_SCALE, 4096, 4096, 0, 0, 0, 0, 0));
		send(mk(3'd6, -1, -1, -1, -1, -1, -1, -1));
		send(mk(3'd7, 1, 2, 3, 4, 5, 6, 7));
		for (int n = 0; n < 1700; n++) begin
			calm = (n >= 600 && n < 900);
			w.cmd = ($urandom_range(15) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(CMD_SCALE));
			w.a_x = rand_coord(); w.a_y = rand_coord();
			w.b_x = rand_coord(); w.b_y = rand_coord();
			w.a_mag = $urandom_range(1) ? 23'($urandom) : 23'($urandom_range(65535));
			w.a_ang = ANG_W'($urandom);
			w.factor = $urandom_range(1) ? 16'($urandom)
				: 16'($signed($urandom_range(1023)) - 512);
			if ($urandom_range(31) == 0) begin
				w.a_x = '0; w.a_y = '0;
			end
			send(w);
		end
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/vrp_pkg.sv
hw/rtl/vrp_cordic.sv
hw/rtl/vector_rect_polar_unit.sv
tb/sv/testbench.sv
